[hw/rtl/lru_age_counter_replacement_defines.svh]
// Assertion macros shared by the checker of the LRU age-counter block.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef LRU_AGE_COUNTER_REPLACEMENT_DEFINES_SVH
`define LRU_AGE_COUNTER_REPLACEMENT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lru_acr_pkg.sv]
// Shared constants for the LRU age-counter replacement block.
// No dependencies; imported by the top level, its checker and the testbench.
package lru_acr_pkg;

  // Default sizes of the age store.
  localparam int DEF_NUM_LINES = 64;
  localparam int DEF_AGE_BITS  = 8;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int SET_W   = 6;
  localparam int LINE_W  = 6;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 7;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Width of the scope bounds before clamping: 63 * 127 + 127 fits in 14 bits.
  localparam int SCOPE_W = 14;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_HIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd2;

  // Associativity modes.
  localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_ASSOC = 2'd0;
  localparam logic [1:0] REG_LINES = 2'd1;
  localparam logic [1:0] REG_WAYS  = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0] RST_ASSOC = MODE_FULL;
  localparam logic [CNT_W-1:0]  RST_LINES = 7'd64;
  localparam logic [CNT_W-1:0]  RST_WAYS  = 7'd4;

endpackage

[hw/rtl/lru_age_counter_replacement.sv]
// Top level of the LRU age-counter replacement block: age store, sequencer
// and configuration registers. Depends on lru_acr_pkg.
//
// The block keeps one saturating age counter per cache line in a simple
// dual-port style memory (one write and one registered read per cycle) and
// serves one transaction at a time. After reset it clears the age of every
// line, with item_ready low; configuration writes are taken during that time.
// The scope is the whole active cache in fully associative mode, one set in
// set associative mode, and none in direct mapped or the unused mode. Hits and
// fills walk the scope to age its lines and a victim search walks it to find
// the oldest line. Accesses without a walk (direct mapped mode, a cleared
// flag, an unused operation code, an empty victim scope or an accessed line
// beyond the store) skip that step. The next transaction is accepted at the
// earliest in the cycle after the result is posted. The walk uses a single
// comparator and incrementer that visits one stored age per cycle through
// the memory read port, writing the bumped age back in the cycle after the
// read. A hit first reads the accessed line's age as the reference, a victim
// search keeps the running oldest line (the later one wins on a tie), and
// hits and fills on a line within the store end with a write that clears the
// accessed line's age. The result sits in an output register until it is
// taken, so the sequencer only waits at its last step when an earlier result
// is still pending.
module lru_age_counter_replacement
  import lru_acr_pkg::*;
#(
  parameter int NUM_LINES = DEF_NUM_LINES,
  parameter int AGE_BITS  = DEF_AGE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // Input transactions.
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [OP_W-1:0]    op,
  input  logic [SET_W-1:0]   set_index,
  input  logic [LINE_W-1:0]  line_index,
  input  logic               line_valid,
  // Result transactions.
  output logic               result_valid,
  input  logic               result_ready,
  output logic [LINE_W-1:0]  chosen_line,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IW   = $clog2(NUM_LINES);
  localparam int CW   = $clog2(NUM_LINES + 1);
  localparam int CURW = IW + LINE_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX     = {AGE_BITS{1'b1}};
  localparam logic [SCOPE_W-1:0]  NUM_LINES_S = SCOPE_W'(NUM_LINES);
  localparam logic [CW-1:0]       LAST_LINE   = CW'(NUM_LINES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_REF,
    ST_WALK,
    ST_CLR_CUR,
    ST_FINISH
  } state_t;

  // Configuration registers.
  logic [MODE_W-1:0] assoc_mode;
  logic [CNT_W-1:0]  line_count;
  logic [CNT_W-1:0]  ways_per_set;

  // Sequencer state.
  state_t            state;
  logic [CW-1:0]     clr_cnt;
  logic [OP_W-1:0]   op_q;
  logic [SET_W-1:0]  set_q;
  logic [LINE_W-1:0] cur_q;
  logic              valid_q;
  logic [CW-1:0]     k;
  logic [CW-1:0]     hi;
  logic              p_vld;
  logic [IW-1:0]     p_addr;
  logic [AGE_BITS-1:0] ref_age;
  logic [AGE_BITS-1:0] best;
  logic [IW-1:0]     pick;
  logic              use_pick;

  // Age store.
  logic [AGE_BITS-1:0] age_mem [NUM_LINES];
  logic [AGE_BITS-1:0] rd_data;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [AGE_BITS-1:0] wr_data;

  // Scope and accessed-line decode.
  logic [SCOPE_W-1:0] prod;
  logic [SCOPE_W-1:0] lo_c;
  logic [SCOPE_W-1:0] hi_c;
  logic               has_scope;
  logic [CURW-1:0]    cur_wide;
  logic               cur_ok;
  logic [IW-1:0]      cur_idx;
  logic [CURW-1:0]    pick_wide;
  logic               bump_ok;

  assign pready     = 1'b1;
  assign item_ready = (state == ST_IDLE);

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_mode   <= RST_ASSOC;
      line_count   <= RST_LINES;
      ways_per_set <= RST_WAYS;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ASSOC: assoc_mode   <= pwdata[MODE_W-1:0];
        REG_LINES: line_count   <= pwdata[CNT_W-1:0];
        REG_WAYS:  ways_per_set <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ASSOC: prdata = PDATA_W'(assoc_mode);
      REG_LINES: prdata = PDATA_W'(line_count);
      REG_WAYS:  prdata = PDATA_W'(ways_per_set);
      default:   prdata = '0;
    endcase
  end

  // The scope [lo, hi) of the held transaction, clamped to the store.
  always_comb begin
    prod = SCOPE_W'(set_q) * SCOPE_W'(ways_per_set);
    if (assoc_mode == MODE_FULL) begin
      lo_c      = '0;
      hi_c      = SCOPE_W'(line_count);
      has_scope = 1'b1;
    end else if (assoc_mode == MODE_SET) begin
      lo_c      = prod;
      hi_c      = prod + SCOPE_W'(ways_per_set);
      has_scope = 1'b1;
    end else begin
      lo_c      = '0;
      hi_c      = '0;
      has_scope = 1'b0;
    end
    if (hi_c > NUM_LINES_S) begin
      hi_c = NUM_LINES_S;
    end
    if (lo_c > hi_c) begin
      lo_c = hi_c;
    end
  end

  assign cur_wide  = {{IW{1'b0}}, cur_q};
  assign cur_ok    = (cur_wide < CURW'(NUM_LINES));
  assign cur_idx   = cur_wide[IW-1:0];
  assign pick_wide = {{LINE_W{1'b0}}, pick};

  // A hit ages only lines younger than the accessed one; a fill ages all; neither ages a line at the maximum.
  assign bump_ok = (op_q == OP_FILL || rd_data < ref_age) && (rd_data != AGE_MAX);

  // Memory port control.
  always_comb begin
    rd_addr = (state == ST_SETUP) ? cur_idx : k[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = p_addr;
    wr_data = rd_data + AGE_BITS'(1);
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt[IW-1:0];
        wr_data = '0;
      end
      ST_WALK: begin
        wr_en = p_vld && (op_q != OP_VICTIM) && bump_ok;
      end
      ST_CLR_CUR: begin
        wr_en   = 1'b1;
        wr_addr = cur_idx;
        wr_data = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      age_mem[wr_addr] <= wr_data;
    end
    rd_data <= age_mem[rd_addr];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      p_vld        <= 1'b0;
      use_pick     <= 1'b0;
    end else begin
      // A taken result is dropped here unless the last step posts a new one.
      if (result_valid && result_ready && state != ST_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == LAST_LINE) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            op_q    <= op;
            set_q   <= set_index;
            cur_q   <= line_index;
            valid_q <= line_valid;
            state   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          k        <= lo_c[CW-1:0];
          hi       <= hi_c[CW-1:0];
          p_vld    <= 1'b0;
          use_pick <= (op_q == OP_VICTIM) && has_scope && (lo_c < hi_c);
          best     <= '0;
          pick     <= lo_c[IW-1:0];
          if (op_q == OP_HIT || op_q == OP_FILL) begin
            if (!cur_ok) begin
              state <= ST_FINISH;
            end else if (has_scope && valid_q) begin
              state <= (op_q == OP_HIT) ? ST_REF : ST_WALK;
            end else begin
              state <= ST_CLR_CUR;
            end
          end else if (op_q == OP_VICTIM && has_scope && lo_c < hi_c) begin
            state <= ST_WALK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_REF: begin
          ref_age <= rd_data;
          state   <= ST_WALK;
        end
        ST_WALK: begin
          // Retire the age read in the previous cycle.
          if (p_vld && op_q == OP_VICTIM && rd_data >= best) begin
            best <= rd_data;
            pick <= p_addr;
          end
          if (k != hi) begin
            p_vld  <= 1'b1;
            p_addr <= k[IW-1:0];
            k      <= k + CW'(1);
          end else begin
            p_vld <= 1'b0;
            state <= (op_q == OP_VICTIM) ? ST_FINISH : ST_CLR_CUR;
          end
        end
        ST_CLR_CUR: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            chosen_line  <= use_pick ? pick_wide[LINE_W-1:0] : cur_q;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/lru_acr_checker.sv]
// Port-level checker for the LRU age-counter block and its bind statement.
// Depends on lru_acr_pkg and lru_age_counter_replacement_defines.svh.
`include "lru_age_counter_replacement_defines.svh"

module lru_acr_checker
  import lru_acr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [LINE_W-1:0] chosen_line
);

  // A pending result holds its value until it is taken.
  `LRU_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(chosen_line), "result changed while stalled")

  // The block works on one transaction at a time.
  `LRU_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready, "input accepted while busy")

  // No result can appear in the cycle right after an input is accepted.
  `LRU_ASSERT_NEXT(a_no_instant_result, clk, rst, item_valid && item_ready, !$rose(result_valid), "result appeared too early")

endmodule

bind lru_age_counter_replacement lru_acr_checker u_lru_acr_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the LRU age-counter replacement block: directed and random transactions
// checked against a cycle-free mirror of the age store. Depends on lru_acr_pkg and the RTL.

module tb_top;
  import lru_acr_pkg::*;

  // Sizes of the instance under test; the mirror below is built at the same sizes.
  localparam int NUM_LINES = DEF_NUM_LINES;
  localparam int AGE_BITS  = DEF_AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Codes that the package leaves unnamed but that the fields can still carry.
  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0]        REG_NONE    = 2'd3;

  // Run control. The limit assumes the slowest legal run (every transaction walking all
  // lines, long sender gaps, long receiver stalls) and leaves several times that margin.
  localparam int LIMIT_CYCLES = 800000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [OP_W-1:0]    op = OP_HIT;
  logic [SET_W-1:0]   set_index = '0;
  logic [LINE_W-1:0]  line_index = '0;
  logic               line_valid = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [LINE_W-1:0]  chosen_line;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lru_age_counter_replacement #(
    .NUM_LINES(NUM_LINES),
    .AGE_BITS (AGE_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .op          (op),
    .set_index   (set_index),
    .line_index  (line_index),
    .line_valid  (line_valid),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .chosen_line (chosen_line),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block: one age per line plus the three configuration registers.
  logic [AGE_BITS-1:0] age_mirror [NUM_LINES];
  logic [MODE_W-1:0]   mode_m;
  logic [CNT_W-1:0]    lines_m;
  logic [CNT_W-1:0]    ways_m;

  // Chosen lines still owed by the block, oldest first.
  logic [LINE_W-1:0] chosen_q [$];
  logic [LINE_W-1:0] want_line;
  int err_count = 0;
  int cycle_count = 0;

  // When set, both sides stop idling; this gives the long stretch without gaps.
  bit steady = 1'b0;

  // The receiver owns its hold-off counter; the test only bumps a request count.
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Applies one transaction to the mirror and returns the line the block must report.
  // The scope is [lo, hi) after clamping to the storage; modes other than fully and set
  // associative have no scope at all, so hit and fill only clear the accessed age.
  function automatic logic [LINE_W-1:0] lru_predict(input logic [OP_W-1:0] o,
                                                    input logic [SET_W-1:0] s,
                                                    input logic [LINE_W-1:0] ln,
                                                    input logic v);
    int lo;
    int hi;
    int k;
    bit has;
    logic [AGE_BITS-1:0] ref_age;
    logic [AGE_BITS-1:0] best;
    logic [LINE_W-1:0] pick;
    has = 1'b0;
    lo = 0;
    hi = 0;
    pick = ln;
    if (mode_m == MODE_FULL) begin
      has = 1'b1;
      hi = int'(lines_m);
    end else if (mode_m == MODE_SET) begin
      has = 1'b1;
      lo = int'(s) * int'(ways_m);
      hi = lo + int'(ways_m);
    end
    if (hi > NUM_LINES) hi = NUM_LINES;
    if (lo > hi) lo = hi;
    if (o == OP_HIT || o == OP_FILL) begin
      // The reference age is taken before any bump; the accessed line is never
      // younger than itself, so a hit never bumps it, and it is cleared either way.
      if (has && v) begin
        ref_age = age_mirror[ln];
        for (k = lo; k < hi; k++) begin
          if ((o == OP_FILL || age_mirror[k] < ref_age) && age_mirror[k] != AGE_MAX)
            age_mirror[k] = age_mirror[k] + 1'b1;
        end
      end
      age_mirror[ln] = '0;
    end else if (o == OP_VICTIM) begin
      // Oldest line in scope; ">=" lets the later line win a tie.
      if (has && lo < hi) begin
        best = age_mirror[lo];
        pick = LINE_W'(lo);
        for (k = lo; k < hi; k++) begin
          if (age_mirror[k] >= best) begin
            best = age_mirror[k];
            pick = LINE_W'(k);
          end
        end
      end
    end
    return pick;
  endfunction

  // Cycle limit: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver. Outside a hold-off it drops ready on about a quarter of the cycles, which
  // lands stalls on every phase of the block's work.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (steady) begin
      result_ready <= 1'b1;
    end else begin
      result_ready <= ($urandom_range(99) >= 25);
    end
  end

  // Result checker: every accepted result transaction is matched with the oldest
  // expectation. Values are sampled right after the edge, so they are the ones that the
  // edge itself saw.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (chosen_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual chosen_line %0d",
                 $time, chosen_line);
        err_count++;
      end else begin
        want_line = chosen_q.pop_front();
        if (chosen_line !== want_line) begin
          $display("%0t: chosen_line mismatch, expected %0d, actual %0d",
                   $time, want_line, chosen_line);
          err_count++;
        end
      end
    end
  end

  // Offers one input transaction and holds it until it is accepted. The valid line is
  // lowered only when a gap is taken, so it never gets two assignments in one step.
  task automatic send_item(input logic [OP_W-1:0] o, input logic [SET_W-1:0] s,
                           input logic [LINE_W-1:0] ln, input logic v);
    int gap;
    if (!steady && $urandom_range(99) < 25) begin
      gap = ($urandom_range(99) < 5) ? $urandom_range(80, 1) : $urandom_range(8, 1);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    set_index <= s;
    line_index <= ln;
    line_valid <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    chosen_q.push_back(lru_predict(o, s, ln, v));
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (chosen_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads one register back and compares its field with the mirror.
  task automatic check_reg(input logic [1:0] idx);
    logic [PDATA_W-1:0] data;
    logic [CNT_W-1:0] got;
    logic [CNT_W-1:0] want;
    apb_read(idx, data);
    if (idx == REG_ASSOC) begin
      got = CNT_W'(data[MODE_W-1:0]);
      want = CNT_W'(mode_m);
    end else begin
      got = data[CNT_W-1:0];
      want = (idx == REG_LINES) ? lines_m : ways_m;
    end
    if (got !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, got);
      err_count++;
    end
  endtask

  // Writes a register once the block is idle, mirrors it at the access edge and reads
  // it back. A write to the unused address must leave all three registers alone.
  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ASSOC: mode_m = val[MODE_W-1:0];
      REG_LINES: lines_m = val[CNT_W-1:0];
      REG_WAYS:  ways_m = val[CNT_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_NONE) begin
      check_reg(REG_ASSOC);
      check_reg(REG_LINES);
      check_reg(REG_WAYS);
    end else begin
      check_reg(idx);
    end
  endtask

  task automatic set_config(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] l,
                            input logic [CNT_W-1:0] w, input bit junk_high);
    logic [PDATA_W-1:0] hi_bits;
    hi_bits = junk_high ? ($urandom & ~32'h7F) : '0;
    apb_write(REG_ASSOC, hi_bits | PDATA_W'(m));
    apb_write(REG_LINES, hi_bits | PDATA_W'(l));
    apb_write(REG_WAYS, hi_bits | PDATA_W'(w));
  endtask

  // Random transaction shaped by the current configuration: most accesses land on a
  // line inside the scope (and a set that exists), the rest are anywhere.
  task automatic send_random_item();
    logic [OP_W-1:0] o;
    logic [SET_W-1:0] s;
    logic [LINE_W-1:0] ln;
    logic v;
    int pick;
    int w;
    int nsets;
    int base;
    int span;
    pick = $urandom_range(99);
    if (pick < 35) o = OP_HIT;
    else if (pick < 65) o = OP_FILL;
    else if (pick < 95) o = OP_VICTIM;
    else o = OP_UNUSED;
    s = SET_W'($urandom);
    ln = LINE_W'($urandom);
    v = ($urandom_range(99) < 80);
    w = int'(ways_m);
    if (mode_m == MODE_SET && w != 0 && $urandom_range(99) < 85) begin
      nsets = (NUM_LINES + w - 1) / w;
      s = SET_W'($urandom_range(nsets - 1));
      base = int'(s) * w;
      span = (base + w > NUM_LINES) ? NUM_LINES - base : w;
      if ($urandom_range(99) < 85) ln = LINE_W'(base + $urandom_range(span - 1));
    end else if (mode_m == MODE_FULL && lines_m != 0 && $urandom_range(99) < 85) begin
      span = (int'(lines_m) > NUM_LINES) ? NUM_LINES : int'(lines_m);
      ln = LINE_W'($urandom_range(span - 1));
    end
    send_item(o, s, ln, v);
  endtask

  // Register defaults are read during the clearing pass, then a few transactions run in
  // the reset configuration: a victim on fresh ages must pick the last line.
  task automatic test_reset_values();
    check_reg(REG_ASSOC);
    check_reg(REG_LINES);
    check_reg(REG_WAYS);
    send_item(OP_VICTIM, 6'd0, 6'd0, 1'b1);
    send_item(OP_FILL, 6'd0, 6'd5, 1'b1);
    send_item(OP_HIT, 6'd63, 6'd63, 1'b1);
    send_item(OP_HIT, 6'd0, 6'd7, 1'b0);
    send_item(OP_UNUSED, 6'd0, 6'd9, 1'b1);
    send_item(OP_VICTIM, 6'd0, 6'd0, 1'b0);
  endtask

  // Direct mapped and the unused mode only clear ages; a victim echoes the line index.
  task automatic test_direct_mapped();
    apb_write(REG_ASSOC, PDATA_W'(MODE_DIRECT));
    send_item(OP_FILL, 6'd3, 6'd12, 1'b1);
    send_item(OP_HIT, 6'd0, 6'd63, 1'b1);
    send_item(OP_VICTIM, 6'd1, 6'd40, 1'b1);
    apb_write(REG_ASSOC, PDATA_W'(MODE_UNUSED));
    send_item(OP_HIT, 6'd0, 6'd0, 1'b1);
    send_item(OP_VICTIM, 6'd63, 6'd21, 1'b1);
  endtask

  // Set associative: an access outside its own set, a set beyond the storage, zero
  // ways, and ways wide enough that the scope is clamped to the storage.
  task automatic test_set_assoc();
    set_config(MODE_SET, 7'd64, 7'd4, 1'b0);
    send_item(OP_FILL, 6'd2, 6'd9, 1'b1);
    send_item(OP_HIT, 6'd2, 6'd3, 1'b1);
    send_item(OP_VICTIM, 6'd2, 6'd0, 1'b1);
    send_item(OP_VICTIM, 6'd63, 6'd17, 1'b1);
    apb_write(REG_WAYS, 32'd0);
    send_item(OP_VICTIM, 6'd0, 6'd44, 1'b1);
    apb_write(REG_WAYS, 32'd127);
    send_item(OP_VICTIM, 6'd0, 6'd1, 1'b1);
    apb_write(REG_WAYS, 32'd64);
    send_item(OP_VICTIM, 6'd1, 6'd30, 1'b1);
  endtask

  // Fully associative bounds: an empty cache, a count beyond the storage, one line,
  // and a write to the unused register address.
  task automatic test_full_assoc_bounds();
    set_config(MODE_FULL, 7'd0, 7'd4, 1'b0);
    send_item(OP_VICTIM, 6'd0, 6'd33, 1'b1);
    send_item(OP_FILL, 6'd0, 6'd33, 1'b1);
    apb_write(REG_LINES, 32'd127);
    send_item(OP_VICTIM, 6'd0, 6'd2, 1'b1);
    apb_write(REG_LINES, 32'd1);
    send_item(OP_FILL, 6'd0, 6'd0, 1'b1);
    send_item(OP_VICTIM, 6'd0, 6'd50, 1'b1);
    apb_write(REG_NONE, 32'h5A);
  endtask

  // Two lines in scope: repeated fills of line 0 drive line 1 past the top of its
  // counter, which must stick at the maximum.
  task automatic test_saturation();
    int n;
    set_config(MODE_FULL, 7'd2, 7'd4, 1'b0);
    for (n = 0; n < 270; n++) send_item(OP_FILL, 6'd0, 6'd0, 1'b1);
    send_item(OP_VICTIM, 6'd0, 6'd0, 1'b1);
    send_item(OP_HIT, 6'd0, 6'd1, 1'b1);
    send_item(OP_VICTIM, 6'd0, 6'd0, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering without
  // gaps, so the output register fills and the block must stall its input.
  task automatic test_backpressure();
    int n;
    set_config(MODE_SET, 7'd64, 7'd8, 1'b0);
    hold_asked++;
    steady = 1'b1;
    for (n = 0; n < 40; n++) send_random_item();
    steady = 1'b0;
  endtask

  // Random traffic in phases. The first phases pin the extremes of the registers, one of
  // them runs with no idling on either side, and the rest draw registers at random.
  task automatic test_random_traffic();
    int ph;
    int n;
    int pick;
    logic [MODE_W-1:0] m;
    logic [CNT_W-1:0] l;
    logic [CNT_W-1:0] w;
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(MODE_FULL, 7'd64, 7'd4, 1'b0);
        1: set_config(MODE_SET, 7'd64, 7'd1, 1'b1);
        2: set_config(MODE_SET, 7'd3, 7'd127, 1'b1);
        3: set_config(MODE_FULL, 7'd1, 7'd64, 1'b0);
        4: set_config(MODE_SET, 7'd0, 7'd64, 1'b1);
        default: begin
          pick = $urandom_range(99);
          if (pick < 40) m = MODE_FULL;
          else if (pick < 85) m = MODE_SET;
          else if (pick < 95) m = MODE_DIRECT;
          else m = MODE_UNUSED;
          l = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(127))
                                       : CNT_W'($urandom_range(16, 1));
          w = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(127))
                                       : CNT_W'($urandom_range(8, 1));
          set_config(m, l, w, 1'b1);
        end
      endcase
      // Phase three runs as one long stretch without idling on either side.
      steady = (ph == 3);
      for (n = 0; n < 100; n++) send_random_item();
    end
    steady = 1'b0;
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_LINES; k++) age_mirror[k] = '0;
    mode_m = RST_ASSOC;
    lines_m = RST_LINES;
    ways_m = RST_WAYS;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_direct_mapped();
    test_set_assoc();
    test_full_assoc_bounds();
    test_saturation();
    test_backpressure();
    test_random_traffic();

    // Let every owed result arrive, then give the block time to show a stray one.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && chosen_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lru_acr_pkg.sv
hw/rtl/lru_age_counter_replacement.sv
hw/rtl/lru_acr_checker.sv
tb/tb_top.sv
